### design/tzoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzoc_pkg
// Shared types, constants and calendar helpers for the time zone offset
// converter.
// ----------------------------------------------------------------------------
package tzoc_pkg;

   // Calendar limits.
   localparam logic [13:0] YEAR_MIN        = 14'd1;
   localparam logic [13:0] YEAR_MAX        = 14'd9999;
   localparam logic [3:0]  MONTH_JAN       = 4'd1;
   localparam logic [3:0]  MONTH_FEB       = 4'd2;
   localparam logic [3:0]  MONTH_DEC       = 4'd12;
   localparam logic [4:0]  DAY_FIRST       = 5'd1;
   localparam logic [4:0]  HOUR_MAX        = 5'd23;
   localparam logic [5:0]  MINUTE_MAX      = 6'd59;
   localparam logic [2:0]  WEEKDAY_SAT     = 3'd6;
   localparam logic [2:0]  WEEKDAY_WRAP    = 3'd7;
   localparam int          MIN_PER_HOUR    = 60;
   localparam int          HOURS_PER_DAY   = 24;

   // Bias register limits and reset value.
   localparam logic signed [11:0] BIAS_LIMIT = 12'sd1440;
   localparam logic signed [11:0] BIAS_RESET = -12'sd480;

   // Divisibility by 25 on 14-bit years: multiply by the inverse of 25
   // modulo 2^14; the low bits fall at or below the limit exactly for
   // multiples of 25.
   localparam logic [13:0] INV25       = 14'd7209;
   localparam logic [13:0] DIV25_LIMIT = 14'd655;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // One input beat.
   typedef struct packed {
      logic        operation;
      logic [13:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
      logic [4:0]  in_hour;
      logic [5:0]  in_minute;
      logic [5:0]  in_second;
      logic [9:0]  in_millisecond;
      logic [2:0]  in_weekday;
   } req_payload_type;

   // One result beat.
   typedef struct packed {
      logic [13:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
      logic [9:0]  out_millisecond;
      logic [2:0]  out_weekday;
   } rsp_payload_type;

   // Bias split into hours and minutes, held by the register block.
   typedef struct packed {
      logic       neg;
      logic [4:0] hours;
      logic [5:0] minutes;
   } bias_type;

   // Whole day crossed by the time-of-day adjustment.
   typedef struct packed {
      logic fwd;
      logic back;
   } day_step_type;

   // Gregorian leap year test for a year already held within range.
   function automatic logic is_leap(input logic [13:0] year);
      logic [13:0] prod;
      logic        div25;
      prod  = 14'(year * INV25);
      div25 = (prod <= DIV25_LIMIT);
      return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
   endfunction

   // Number of days in a month.
   function automatic logic [4:0] days_in(input logic leap, input logic [3:0] month);
      logic [4:0] n;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
         MONTH_FEB:                                  n = leap ? 5'd29 : 5'd28;
         default:                                    n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

### design/tzoc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzoc_req_if
// Valid/ready channel carrying one date-time to convert per beat.
// ----------------------------------------------------------------------------
interface tzoc_req_if
   import tzoc_pkg::*;
   ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/tzoc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzoc_rsp_if
// Valid/ready channel carrying one converted date-time per beat.
// ----------------------------------------------------------------------------
interface tzoc_rsp_if
   import tzoc_pkg::*;
   ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/tzoc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzoc_csr
// APB-style register block holding the saturated zone bias, with the bias
// also kept split into whole hours and minutes for the datapath.
// ----------------------------------------------------------------------------
module tzoc_csr
   import tzoc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output bias_type              bias
);

   localparam logic       REG_BIAS_MINUTES = 1'b0;
   localparam logic [4:0] RESET_HOURS      = 5'((-BIAS_RESET) / MIN_PER_HOUR);
   localparam logic [5:0] RESET_MINUTES    = 6'((-BIAS_RESET) % MIN_PER_HOUR);

   logic signed [11:0] bias_ff;
   logic signed [11:0] bias_in;
   bias_type           split_ff;
   bias_type           split_in;
   logic               wr_en;
   logic signed [11:0] wr_value;
   logic [10:0]        mag;
   logic [4:0]         hours;

   // A write lands in the access phase; the word address picks the register.
   assign wr_en    = psel && penable && pwrite && (paddr[2] == REG_BIAS_MINUTES);
   assign wr_value = signed'(pwdata[11:0]);

   // Saturate the written value and split its magnitude into hours and minutes.
   always_comb begin
      if (wr_value > BIAS_LIMIT) begin
         bias_in = BIAS_LIMIT;
      end else if (wr_value < -BIAS_LIMIT) begin
         bias_in = -BIAS_LIMIT;
      end else begin
         bias_in = wr_value;
      end
      mag   = bias_in[11] ? 11'(-bias_in) : 11'(bias_in);
      hours = '0;
      for (int k = 1; k <= HOURS_PER_DAY; k++) begin
         hours = hours + 5'(mag >= 11'(k * MIN_PER_HOUR));
      end
      split_in.neg     = bias_in[11];
      split_in.hours   = hours;
      split_in.minutes = 6'(mag - (11'({hours, 6'b0}) - 11'({hours, 2'b0})));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff          <= BIAS_RESET;
         split_ff.neg     <= 1'b1;
         split_ff.hours   <= RESET_HOURS;
         split_ff.minutes <= RESET_MINUTES;
      end else if (wr_en) begin
         bias_ff  <= bias_in;
         split_ff <= split_in;
      end
   end

   // Read back the held bias, sign-extended.
   assign prdata = {{(CSR_DATA_W-12){bias_ff[11]}}, bias_ff};
   assign pready = 1'b1;
   assign bias   = split_ff;

endmodule

### design/tzoc_clock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzoc_clock
// Time-of-day adjustment: adds or subtracts the bias hours and the bias
// minutes, and flags a day crossed in either direction.
// ----------------------------------------------------------------------------
module tzoc_clock
   import tzoc_pkg::*;
(
   input  logic         operation,
   input  logic [4:0]   hour,
   input  logic [5:0]   minute,
   input  bias_type     bias,
   output logic [4:0]   out_hour,
   output logic [5:0]   out_minute,
   output day_step_type step
);

   logic              go_back;
   logic [4:0]        hour_c;
   logic [5:0]        minute_c;
   logic signed [7:0] min_sum;
   logic signed [7:0] min_fix;
   logic              min_carry;
   logic signed [6:0] hour_sum;

   // Clamp out-of-range hour and minute.
   assign hour_c   = (hour > HOUR_MAX) ? HOUR_MAX : hour;
   assign minute_c = (minute > MINUTE_MAX) ? MINUTE_MAX : minute;

   // The shift runs backwards when the bias sign matches the add operation
   // being chosen for a negative bias, or subtract for a positive one.
   assign go_back = (bias.neg == operation);

   always_comb begin
      // Minutes first, with a carry or borrow into the hours.
      if (go_back) begin
         min_sum = signed'({2'b00, minute_c}) - signed'({2'b00, bias.minutes});
      end else begin
         min_sum = signed'({2'b00, minute_c}) + signed'({2'b00, bias.minutes});
      end
      min_carry = 1'b0;
      min_fix   = min_sum;
      if (min_sum < 0) begin
         min_fix   = min_sum + 8'(MIN_PER_HOUR);
         min_carry = 1'b1;
      end else if (min_sum >= 8'(MIN_PER_HOUR)) begin
         min_fix   = min_sum - 8'(MIN_PER_HOUR);
         min_carry = 1'b1;
      end

      // Hours next; a wrap past midnight crosses one day.
      if (go_back) begin
         hour_sum = signed'({2'b00, hour_c}) - signed'({2'b00, bias.hours})
                    - 7'(min_carry);
      end else begin
         hour_sum = signed'({2'b00, hour_c}) + signed'({2'b00, bias.hours})
                    + 7'(min_carry);
      end
      step.fwd  = 1'b0;
      step.back = 1'b0;
      if (hour_sum < 0) begin
         hour_sum  = hour_sum + 7'(HOURS_PER_DAY);
         step.back = 1'b1;
      end else if (hour_sum >= 7'(HOURS_PER_DAY)) begin
         hour_sum  = hour_sum - 7'(HOURS_PER_DAY);
         step.fwd  = 1'b1;
      end
      out_hour   = 5'(hour_sum);
      out_minute = 6'(min_fix);
   end

endmodule

### design/tzoc_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tzoc_date
// Calendar date roll: moves the date and weekday one day forwards or
// backwards across month and year ends, with Gregorian leap years.
// ----------------------------------------------------------------------------
module tzoc_date
   import tzoc_pkg::*;
(
   input  logic [13:0]  year,
   input  logic [3:0]   month,
   input  logic [4:0]   day,
   input  logic [2:0]   weekday,
   input  day_step_type step,
   output logic [13:0]  out_year,
   output logic [3:0]   out_month,
   output logic [4:0]   out_day,
   output logic [2:0]   out_weekday
);

   logic [13:0] year_c;
   logic [3:0]  month_c;
   logic [4:0]  day_c;
   logic [2:0]  wd_c;
   logic        leap;
   logic [4:0]  dim;
   logic [3:0]  month_prev;
   logic [4:0]  dim_prev;

   // Bring the input into range.
   always_comb begin
      if (year < YEAR_MIN) begin
         year_c = YEAR_MIN;
      end else if (year > YEAR_MAX) begin
         year_c = YEAR_MAX;
      end else begin
         year_c = year;
      end
      if (month < MONTH_JAN) begin
         month_c = MONTH_JAN;
      end else if (month > MONTH_DEC) begin
         month_c = MONTH_DEC;
      end else begin
         month_c = month;
      end
   end

   assign leap       = is_leap(year_c);
   assign dim        = days_in(leap, month_c);
   assign month_prev = (month_c == MONTH_JAN) ? MONTH_DEC : month_c - 4'd1;
   // Stepping back from January lands in December, whose length ignores leap.
   assign dim_prev   = days_in(leap, month_prev);
   assign wd_c       = (weekday == WEEKDAY_WRAP) ? 3'd0 : weekday;

   always_comb begin
      if (day < DAY_FIRST) begin
         day_c = DAY_FIRST;
      end else if (day > dim) begin
         day_c = dim;
      end else begin
         day_c = day;
      end
   end

   // Apply the day crossed, if any.
   always_comb begin
      out_year    = year_c;
      out_month   = month_c;
      out_day     = day_c;
      out_weekday = wd_c;
      priority if (step.fwd) begin
         out_weekday = (wd_c == WEEKDAY_SAT) ? 3'd0 : wd_c + 3'd1;
         if (day_c == dim) begin
            out_day = DAY_FIRST;
            if (month_c == MONTH_DEC) begin
               out_month = MONTH_JAN;
               out_year  = year_c + 14'd1;
            end else begin
               out_month = month_c + 4'd1;
            end
         end else begin
            out_day = day_c + 5'd1;
         end
      end else if (step.back) begin
         out_weekday = (wd_c == 3'd0) ? WEEKDAY_SAT : wd_c - 3'd1;
         if (day_c == DAY_FIRST) begin
            out_month = month_prev;
            out_day   = dim_prev;
            if (month_c == MONTH_JAN) begin
               out_year = year_c - 14'd1;
            end
         end else begin
            out_day = day_c - 5'd1;
         end
      end else begin
         out_day = day_c;
      end
   end

endmodule

### design/time_zone_offset_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_zone_offset_convert
// Moves a calendar date-time by the configured zone bias, rolling the date,
// month, year and weekday across at most one day.
// An accepted request beat passes through the input register, then the
// result register, before it leaves as its response beat.
// Throughput: one beat per cycle while rsp_chan.ready holds; each register
// stage moves on when the stage after it is empty or being emptied.
// Reset: synchronous; empties both stages and loads a bias of -480 minutes.
// ----------------------------------------------------------------------------
module time_zone_offset_convert
   import tzoc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tzoc_req_if.sink              req_chan,
   tzoc_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   bias_type        bias;
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   logic            in_ready;
   logic            out_ready;
   day_step_type    step;

   tzoc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .bias    (bias)
   );

   // Stage readiness: a stage takes a beat when it is empty or draining.
   assign out_ready      = !out_valid_ff || rsp_chan.ready;
   assign in_ready       = !in_valid_ff || out_ready;
   assign req_chan.ready = in_ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_data_ff <= req_chan.payload;
      end
   end

   // Conversion between the two registers.
   tzoc_clock u_clock (
      .operation  (in_data_ff.operation),
      .hour       (in_data_ff.in_hour),
      .minute     (in_data_ff.in_minute),
      .bias       (bias),
      .out_hour   (out_data_in.out_hour),
      .out_minute (out_data_in.out_minute),
      .step       (step)
   );

   tzoc_date u_date (
      .year        (in_data_ff.in_year),
      .month       (in_data_ff.in_month),
      .day         (in_data_ff.in_day),
      .weekday     (in_data_ff.in_weekday),
      .step        (step),
      .out_year    (out_data_in.out_year),
      .out_month   (out_data_in.out_month),
      .out_day     (out_data_in.out_day),
      .out_weekday (out_data_in.out_weekday)
   );

   assign out_data_in.out_second      = in_data_ff.in_second;
   assign out_data_in.out_millisecond = in_data_ff.in_millisecond;

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

endmodule
